>>> rtl/csv_stream_parser_unit_defines.svh
// assertion macros shared by the csv parser checker
`ifndef CSV_STREAM_PARSER_UNIT_DEFINES_SVH
`define CSV_STREAM_PARSER_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define CSVP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvp: same-cycle check failed");

// consequent in the cycle after the antecedent
`define CSVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvp: next-cycle check failed");

`endif

>>> rtl/csvp_pkg.sv
// shared types and constants of the csv stream parser
`default_nettype none

package csvp_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int ROW_WIDTH_DEF   = 16;
    localparam int MAX_RESULTS     = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_AFTER_QUOTE = 3'd1;
    localparam logic [2:0] E_OPEN_QUOTE  = 3'd2;
    localparam logic [2:0] E_COLUMNS     = 3'd3;
    localparam logic [2:0] E_OVERFLOW    = 3'd4;

    typedef enum logic [1:0] {
        K_CONTENT   = 2'd0,
        K_FIELD_END = 2'd1,
        K_DONE      = 2'd2,
        K_ERROR     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  column;
        logic [15:0] row;
        logic        record_end;
        logic        field_empty;
        logic [2:0]  error_code;
        logic        last;
    } t_out_item;

    // results caused by one input transaction
    typedef struct packed {
        logic [1:0]                        count;
        t_out_item [MAX_RESULTS-1:0]       items;
    } t_res_set;

endpackage

`default_nettype wire

>>> rtl/csvp_core.sv
// parse state and results for one input byte per cycle while i_fire
`default_nettype none

module csvp_core #(
    parameter int MAX_COLUMNS = csvp_pkg::MAX_COLUMNS_DEF,
    parameter int ROW_WIDTH   = csvp_pkg::ROW_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire csvp_pkg::t_in_item i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [8:0]         i_cfg_data,
    output csvp_pkg::t_res_set      o_set
);
    import csvp_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = (CW > 9) ? CW : 9;

    typedef enum logic [2:0] {
        M_FIELD  = 3'd0,
        M_QUOTED = 3'd1,
        M_QSEEN  = 3'd2,
        M_CR     = 3'd3,
        M_CRQ    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        A_NONE,
        A_CONTENT,
        A_FIELD,
        A_RECORD,
        A_LATCH
    } t_action;

    t_mode                r_mode, n_mode;
    logic [CW-1:0]        r_col, n_col;
    logic [CW-1:0]        r_learn, n_learn;
    logic [ROW_WIDTH-1:0] r_row, n_row;
    logic                 r_fhc, n_fhc;
    logic                 r_err, n_err;
    logic [2:0]           r_code, n_code;
    logic [8:0]           r_expected;

    logic       eoi;
    logic [7:0] b;
    logic       pre_cr;
    logic       fhc_eff;
    logic       field_sel;
    t_action    act;
    logic [2:0] act_code;

    function automatic t_out_item mk_res(t_kind k, logic [7:0] d, logic [CW-1:0] c,
                                         logic [ROW_WIDTH-1:0] r, logic re, logic fe,
                                         logic [2:0] ec);
        t_out_item            res;
        logic [CW+7:0]        c_ext;
        logic [ROW_WIDTH+15:0] r_ext;
        c_ext           = {8'd0, c};
        r_ext           = {16'd0, r};
        res.kind        = k;
        res.data_byte   = d;
        res.column      = c_ext[7:0];
        res.row         = r_ext[15:0];
        res.record_end  = re;
        res.field_empty = fe;
        res.error_code  = ec;
        res.last        = 1'b0;
        return res;
    endfunction

    // next mode and the single action this byte asks for
    always_comb begin
        b         = i_item.in_byte;
        eoi       = i_item.end_of_input || (b == CH_NUL);
        n_mode    = r_mode;
        pre_cr    = 1'b0;
        fhc_eff   = r_fhc;
        field_sel = 1'b0;
        act       = A_NONE;
        act_code  = E_NONE;
        if (eoi) begin
            n_mode = M_FIELD;
            if (!r_err) begin
                case (r_mode)
                    M_QUOTED: begin
                        act      = A_LATCH;
                        act_code = E_OPEN_QUOTE;
                    end
                    M_CRQ: begin
                        act      = A_LATCH;
                        act_code = E_AFTER_QUOTE;
                    end
                    M_QSEEN: act = A_RECORD;
                    M_CR: begin
                        pre_cr = 1'b1;
                        act    = A_RECORD;
                    end
                    default: begin
                        if (r_col != '0 || r_fhc) act = A_RECORD;
                    end
                endcase
            end
        end else if (!r_err) begin
            case (r_mode)
                M_QUOTED: begin
                    if (b == CH_QUOTE) n_mode = M_QSEEN;
                    else act = A_CONTENT;
                end
                M_QSEEN: begin
                    if (b == CH_QUOTE) begin
                        act    = A_CONTENT;
                        n_mode = M_QUOTED;
                    end else if (b == CH_COMMA) begin
                        act    = A_FIELD;
                        n_mode = M_FIELD;
                    end else if (b == CH_LF) begin
                        act    = A_RECORD;
                        n_mode = M_FIELD;
                    end else if (b == CH_CR) begin
                        n_mode = M_CRQ;
                    end else begin
                        act      = A_LATCH;
                        act_code = E_AFTER_QUOTE;
                    end
                end
                M_CR: begin
                    if (b == CH_LF) begin
                        n_mode = M_FIELD;
                        if (r_col != '0 || r_fhc) act = A_RECORD;
                    end else begin
                        // lone cr becomes content ahead of this byte
                        pre_cr    = 1'b1;
                        fhc_eff   = 1'b1;
                        field_sel = 1'b1;
                    end
                end
                M_CRQ: begin
                    if (b == CH_LF) begin
                        act    = A_RECORD;
                        n_mode = M_FIELD;
                    end else begin
                        act      = A_LATCH;
                        act_code = E_AFTER_QUOTE;
                    end
                end
                default: field_sel = 1'b1;
            endcase
            if (field_sel) begin
                n_mode = M_FIELD;
                if (b == CH_COMMA) begin
                    act = A_FIELD;
                end else if (b == CH_LF) begin
                    if (r_col != '0 || fhc_eff) act = A_RECORD;
                end else if (b == CH_CR) begin
                    n_mode = M_CR;
                end else if (b == CH_QUOTE && !fhc_eff) begin
                    n_mode = M_QUOTED;
                end else begin
                    act = A_CONTENT;
                end
            end
        end
    end

    // counters, error latch and the results of this byte
    always_comb begin
        logic [1:0]                  v_cnt;
        t_out_item [MAX_RESULTS-1:0] v_items;
        logic [RW-1:0]               count;
        logic [RW-1:0]               req;
        v_cnt   = 2'd0;
        v_items = '0;
        count   = '0;
        req     = '0;
        n_col   = r_col;
        n_learn = r_learn;
        n_row   = r_row;
        n_fhc   = r_fhc;
        n_err   = r_err;
        n_code  = r_code;

        if (pre_cr) begin
            v_items[v_cnt] = mk_res(K_CONTENT, CH_CR, n_col, n_row, 1'b0, 1'b0, E_NONE);
            v_cnt          = v_cnt + 2'd1;
            n_fhc          = 1'b1;
        end

        case (act)
            A_CONTENT: begin
                v_items[v_cnt] = mk_res(K_CONTENT, b, n_col, n_row, 1'b0, 1'b0, E_NONE);
                v_cnt          = v_cnt + 2'd1;
                n_fhc          = 1'b1;
            end
            A_FIELD: begin
                if (n_col >= CW'(MAX_COLUMNS)) begin
                    n_err  = 1'b1;
                    n_code = E_OVERFLOW;
                end else begin
                    v_items[v_cnt] = mk_res(K_FIELD_END, 8'd0, n_col, n_row, 1'b0, !n_fhc,
                                            E_NONE);
                    v_cnt          = v_cnt + 2'd1;
                    n_col          = n_col + 1'b1;
                    n_fhc          = 1'b0;
                end
            end
            A_RECORD: begin
                if (n_col >= CW'(MAX_COLUMNS)) begin
                    n_err  = 1'b1;
                    n_code = E_OVERFLOW;
                end else begin
                    v_items[v_cnt] = mk_res(K_FIELD_END, 8'd0, n_col, n_row, 1'b1, !n_fhc,
                                            E_NONE);
                    v_cnt          = v_cnt + 2'd1;
                    count          = RW'(n_col) + RW'(1);
                    req            = (r_expected != '0) ? RW'(r_expected) : RW'(n_learn);
                    if (req != '0 && count != req) begin
                        n_err  = 1'b1;
                        n_code = E_COLUMNS;
                    end else begin
                        if (r_expected == '0 && n_learn == '0) n_learn = count[CW-1:0];
                        if (n_row != '1) n_row = n_row + 1'b1;
                        n_col = '0;
                        n_fhc = 1'b0;
                    end
                end
            end
            A_LATCH: begin
                n_err  = 1'b1;
                n_code = act_code;
            end
            default: ;
        endcase

        if (eoi) begin
            if (!n_err && n_row == '0) begin
                n_err  = 1'b1;
                n_code = E_OVERFLOW;
            end
            if (n_err) begin
                v_items[v_cnt] = mk_res(K_ERROR, 8'd0, n_col, n_row, 1'b0, 1'b0, n_code);
            end else begin
                v_items[v_cnt] = mk_res(K_DONE, 8'd0, '0, n_row, 1'b0, 1'b0, E_NONE);
            end
            v_cnt   = v_cnt + 2'd1;
            // re-arm for the next text
            n_col   = '0;
            n_learn = '0;
            n_row   = '0;
            n_fhc   = 1'b0;
            n_err   = 1'b0;
            n_code  = E_NONE;
        end else if (n_err && !r_err) begin
            v_items[v_cnt] = mk_res(K_ERROR, 8'd0, n_col, n_row, 1'b0, 1'b0, n_code);
            v_cnt          = v_cnt + 2'd1;
        end

        for (int k = 0; k < MAX_RESULTS; k++) begin
            v_items[k].last = (v_cnt == 2'(k + 1));
        end
        o_set.count = v_cnt;
        o_set.items = v_items;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_FIELD;
            r_col      <= '0;
            r_learn    <= '0;
            r_row      <= '0;
            r_fhc      <= 1'b0;
            r_err      <= 1'b0;
            r_code     <= E_NONE;
            r_expected <= '0;
        end else begin
            if (i_fire) begin
                r_mode  <= n_mode;
                r_col   <= n_col;
                r_learn <= n_learn;
                r_row   <= n_row;
                r_fhc   <= n_fhc;
                r_err   <= n_err;
                r_code  <= n_code;
            end
            if (i_cfg_we) r_expected <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/csvp_res_queue.sv
// small result queue: up to three results in at once, one out per ready cycle
`default_nettype none

module csvp_res_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire csvp_pkg::t_res_set i_set,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output csvp_pkg::t_out_item     o_item
);
    import csvp_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_out_item        r_q [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             pop;
    logic [CNTW-1:0]  push_cnt;

    assign o_valid  = (r_cnt != '0);
    assign o_item   = r_q[r_rd];
    assign o_space  = (r_cnt <= CNTW'(QUEUE_DEPTH - MAX_RESULTS));
    assign pop      = o_valid && i_ready;
    assign push_cnt = i_push ? CNTW'(i_set.count) : '0;

    always_comb begin
        n_wr  = r_wr + PW'(push_cnt);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + push_cnt - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (i_push && (k < int'(i_set.count))) begin
                r_q[r_wr + PW'(k)] <= i_set.items[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/csv_stream_parser_unit.sv
// Streaming CSV parser. One text byte (or an end-of-input transaction) is taken per
// cycle while o_in_ready is high and parsed in a single registered step; its zero to
// three results go into a four-entry result queue that delivers one result per cycle
// while i_out_ready is high. Input ready stays high while the queue holds at most one
// result, so bytes that cause one result or none stream at one per cycle while results
// drain. A zero byte ends the input like end_of_input. expected_columns is written
// through i_cfg_we/i_cfg_data; 0 learns the column count from the first record.
`default_nettype none

module csv_stream_parser_unit #(
    parameter int MAX_COLUMNS = csvp_pkg::MAX_COLUMNS_DEF,
    parameter int ROW_WIDTH   = csvp_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire csvp_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output csvp_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [8:0]          i_cfg_data
);
    import csvp_pkg::*;

    t_res_set set;
    logic     fire;
    logic     space;

    assign o_in_ready = space;
    assign fire       = i_in_valid && space;

    csvp_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_WIDTH   (ROW_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_set      (set)
    );

    csvp_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_set   (set),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> rtl/csvp_checker.sv
// port-level checks for the csv parser and their bind
`default_nettype none

`include "csv_stream_parser_unit_defines.svh"

module csvp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire csvp_pkg::t_out_item i_out_item
);
    import csvp_pkg::*;

    logic out_stall;
    logic out_final;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_final = i_out_valid && (i_out_item.kind == K_DONE || i_out_item.kind == K_ERROR);

    // a result that is not taken holds
    `CSVP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_item))

    // queue comes out of reset empty
    `CSVP_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

    // input backpressure only while results are waiting
    `CSVP_ASSERT_SAME(a_stall_has_out, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // done and error always close the transaction
    `CSVP_ASSERT_SAME(a_final_last, i_clk, i_rst_n, out_final, i_out_item.last)

endmodule

bind csv_stream_parser_unit csvp_checker u_csvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire

>>> dv/tb_csv_stream_parser_unit.sv
// self-checking testbench of the csv parser: directed and random text vs a predictor
`default_nettype none

module tb_csv_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import csvp_pkg::*;

    localparam int LIMIT_CYCLES = 20_000;
    localparam logic [15:0] ROW_TOP = 16'hFFFF;

    typedef enum logic [2:0] {
        PM_FIELD  = 3'd0,
        PM_QUOTED = 3'd1,
        PM_QSEEN  = 3'd2,
        PM_CR     = 3'd3,
        PM_CRQ    = 3'd4
    } t_pmode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_data = '0;

    csv_stream_parser_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // parser state kept by the testbench
    logic [8:0]  want_cols;
    t_pmode      pmode;
    logic [8:0]  col_cnt;
    logic [8:0]  learned;
    logic [15:0] row_cnt;
    bit          has_content;
    bit          err_on;
    logic [2:0]  err_code;

    t_out_item   step_out[$];
    t_out_item   csv_results[$];
    t_in_item    text_bytes[$];

    int n_pushed = 0;
    int n_taken = 0;
    int err_cnt = 0;
    int cyc = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int stall_left = 0;
    bit hold_done = 1'b0;

    function automatic void push_res(t_kind k, logic [7:0] d, logic [8:0] c, logic [15:0] r,
                                     bit rend, bit emp, logic [2:0] code);
        t_out_item o;
        if (step_out.size() >= MAX_RESULTS) return;
        o.kind        = k;
        o.data_byte   = d;
        o.column      = c[7:0];
        o.row         = r;
        o.record_end  = rend;
        o.field_empty = emp;
        o.error_code  = code;
        o.last        = 1'b0;
        step_out.push_back(o);
    endfunction

    function automatic void latch_err(logic [2:0] code);
        err_on   = 1'b1;
        err_code = code;
    endfunction

    function automatic void add_content(logic [7:0] b);
        push_res(K_CONTENT, b, col_cnt, row_cnt, 1'b0, 1'b0, E_NONE);
        has_content = 1'b1;
    endfunction

    function automatic void close_field();
        if (col_cnt >= MAX_COLUMNS_DEF) begin
            latch_err(E_OVERFLOW);
            return;
        end
        push_res(K_FIELD_END, 8'h00, col_cnt, row_cnt, 1'b0, !has_content, E_NONE);
        col_cnt     = col_cnt + 1'b1;
        has_content = 1'b0;
        pmode       = PM_FIELD;
    endfunction

    function automatic void close_record();
        logic [9:0] cnt;
        logic [8:0] req;
        if (col_cnt >= MAX_COLUMNS_DEF) begin
            latch_err(E_OVERFLOW);
            return;
        end
        push_res(K_FIELD_END, 8'h00, col_cnt, row_cnt, 1'b1, !has_content, E_NONE);
        cnt = {1'b0, col_cnt} + 10'd1;
        req = (want_cols != 0) ? want_cols : learned;
        if (req != 0 && cnt != {1'b0, req}) begin
            latch_err(E_COLUMNS);
            return;
        end
        if (want_cols == 0 && learned == 0) learned = cnt[8:0];
        if (row_cnt < ROW_TOP) row_cnt = row_cnt + 1'b1;
        col_cnt     = '0;
        has_content = 1'b0;
        pmode       = PM_FIELD;
    endfunction

    function automatic void take_lf();
        pmode = PM_FIELD;
        // a line with no field and no content is skipped
        if (col_cnt == 0 && !has_content) return;
        close_record();
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        if (b == CH_COMMA) close_field();
        else if (b == CH_LF) take_lf();
        else if (b == CH_CR) pmode = PM_CR;
        else if (b == CH_QUOTE && !has_content) pmode = PM_QUOTED;
        else add_content(b);
    endfunction

    function automatic void text_byte(logic [7:0] b);
        case (pmode)
            PM_QUOTED: begin
                if (b == CH_QUOTE) pmode = PM_QSEEN;
                else add_content(b);
            end
            PM_QSEEN: begin
                if (b == CH_QUOTE) begin
                    add_content(CH_QUOTE);
                    pmode = PM_QUOTED;
                end else if (b == CH_COMMA) close_field();
                else if (b == CH_LF) close_record();
                else if (b == CH_CR) pmode = PM_CRQ;
                else latch_err(E_AFTER_QUOTE);
            end
            PM_CR: begin
                if (b == CH_LF) take_lf();
                else begin
                    // lone cr goes out as content ahead of this byte
                    add_content(CH_CR);
                    pmode = PM_FIELD;
                    plain_byte(b);
                end
            end
            PM_CRQ: begin
                if (b == CH_LF) close_record();
                else latch_err(E_AFTER_QUOTE);
            end
            default: begin
                pmode = PM_FIELD;
                plain_byte(b);
            end
        endcase
    endfunction

    function automatic void clear_parse();
        pmode       = PM_FIELD;
        col_cnt     = '0;
        learned     = '0;
        row_cnt     = '0;
        has_content = 1'b0;
        err_on      = 1'b0;
        err_code    = E_NONE;
    endfunction

    function automatic void end_input();
        if (!err_on) begin
            case (pmode)
                PM_QUOTED: latch_err(E_OPEN_QUOTE);
                PM_CRQ:    latch_err(E_AFTER_QUOTE);
                PM_QSEEN:  close_record();
                PM_CR: begin
                    add_content(CH_CR);
                    close_record();
                end
                default: if (col_cnt != 0 || has_content) close_record();
            endcase
            if (!err_on && row_cnt == 0) latch_err(E_OVERFLOW);
        end
        if (err_on) push_res(K_ERROR, 8'h00, col_cnt, row_cnt, 1'b0, 1'b0, err_code);
        else push_res(K_DONE, 8'h00, 9'd0, row_cnt, 1'b0, 1'b0, E_NONE);
        clear_parse();
    endfunction

    function automatic void csv_parse(t_in_item it);
        t_out_item o;
        step_out.delete();
        if (it.end_of_input || it.in_byte == CH_NUL) end_input();
        else if (!err_on) begin
            text_byte(it.in_byte);
            if (err_on) push_res(K_ERROR, 8'h00, col_cnt, row_cnt, 1'b0, 1'b0, err_code);
        end
        if (step_out.size() != 0) begin
            o = step_out.pop_back();
            o.last = 1'b1;
            step_out.push_back(o);
        end
        foreach (step_out[i]) csv_results.push_back(step_out[i]);
    endfunction

    // stimulus helpers
    function automatic void push_byte(logic [7:0] b);
        t_in_item it;
        it.in_byte      = b;
        it.end_of_input = 1'b0;
        text_bytes.push_back(it);
        n_pushed++;
    endfunction

    function automatic void push_eoi(logic [7:0] b);
        t_in_item it;
        it.in_byte      = b;
        it.end_of_input = 1'b1;
        text_bytes.push_back(it);
        n_pushed++;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_CR || c == CH_LF || c == CH_QUOTE)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic void make_field();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 3) return;
        if (pick < 11) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0 && $urandom_range(0, 9) == 0) push_byte(CH_QUOTE);
                else if ($urandom_range(0, 14) == 0) push_byte(CH_CR);
                else push_byte(plain_char());
            end
        end else if (pick < 19) begin
            push_byte(CH_QUOTE);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 7))
                    0: push_byte(CH_COMMA);
                    1: push_byte(CH_CR);
                    2: push_byte(CH_LF);
                    3: begin
                        push_byte(CH_QUOTE);
                        push_byte(CH_QUOTE);
                    end
                    default: push_byte(plain_char());
                endcase
            end
            push_byte(CH_QUOTE);
        end else begin
            // broken quoting: junk or a cr after the closing quote, or no closing quote
            push_byte(CH_QUOTE);
            push_byte(plain_char());
            if ($urandom_range(0, 1) != 0) begin
                push_byte(CH_QUOTE);
                push_byte(($urandom_range(0, 1) != 0) ? plain_char() : CH_CR);
            end
        end
    endfunction

    function automatic void make_doc(int cols);
        int nrec;
        int nf;
        nrec = $urandom_range(1, 4);
        for (int r = 0; r < nrec; r++) begin
            if ($urandom_range(0, 7) == 0) push_byte(CH_LF);
            nf = cols;
            if ($urandom_range(0, 11) == 0) nf = cols + 1;
            else if (cols > 1 && $urandom_range(0, 11) == 0) nf = cols - 1;
            for (int f = 0; f < nf; f++) begin
                if (f != 0) push_byte(CH_COMMA);
                make_field();
            end
            if (r == nrec - 1 && $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) != 0) push_byte(CH_COMMA);
            end else begin
                if ($urandom_range(0, 2) == 0) push_byte(CH_CR);
                push_byte(CH_LF);
            end
        end
        if ($urandom_range(0, 5) == 0) push_byte(CH_NUL);
        else push_eoi(8'($urandom_range(0, 255)));
    endfunction

    function automatic void make_noise();
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
        push_eoi(8'($urandom_range(0, 255)));
    endfunction

    function automatic void random_text(int count);
        int stop;
        stop = n_pushed + count;
        while (n_pushed < stop) begin
            if ($urandom_range(0, 7) == 0) make_noise();
            else make_doc((want_cols != 0) ? int'(want_cols) : $urandom_range(1, 4));
        end
    endfunction

    task automatic write_cols(input logic [8:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        want_cols  = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic wait_drain();
        @(posedge i_clk);
        while (text_bytes.size() != 0 || i_in_valid || csv_results.size() != 0)
            @(posedge i_clk);
        // every byte is taken by now; this only idles before the next phase
        repeat (8) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                csv_parse(i_in_item);
                n_taken <= n_taken + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= text_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready, with one long hold-off so the result queue backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_taken >= 40) begin
            hold_done   <= 1'b1;
            stall_left  <= 150;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (csv_results.size() == 0) begin
                $error("unexpected transaction: kind %0d row %0d", o_out_item.kind,
                       o_out_item.row);
                err_cnt++;
            end else begin
                want = csv_results.pop_front();
                if (o_out_item.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_out_item.kind);
                    err_cnt++;
                end
                if (o_out_item.data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte,
                           o_out_item.data_byte);
                    err_cnt++;
                end
                if (o_out_item.column !== want.column) begin
                    $error("column: expected %0d, got %0d", want.column, o_out_item.column);
                    err_cnt++;
                end
                if (o_out_item.row !== want.row) begin
                    $error("row: expected %0d, got %0d", want.row, o_out_item.row);
                    err_cnt++;
                end
                if (o_out_item.record_end !== want.record_end) begin
                    $error("record_end: expected %0d, got %0d", want.record_end,
                           o_out_item.record_end);
                    err_cnt++;
                end
                if (o_out_item.field_empty !== want.field_empty) begin
                    $error("field_empty: expected %0d, got %0d", want.field_empty,
                           o_out_item.field_empty);
                    err_cnt++;
                end
                if (o_out_item.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           o_out_item.error_code);
                    err_cnt++;
                end
                if (o_out_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_item.last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        want_cols = '0;
        clear_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender sends more often than it idles, receiver idles more often
        send_idle <= 38;
        recv_idle <= 45;
        write_cols(9'd0);

        // quoted field with comma and doubled quote, lone cr, empty line,
        // quote inside a plain field, trailing comma, column mismatch at end
        push_byte(CH_QUOTE);
        push_byte(8'h61);
        push_byte(CH_COMMA);
        push_byte(CH_QUOTE);
        push_byte(CH_QUOTE);
        push_byte(CH_QUOTE);
        push_byte(CH_COMMA);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_byte(8'h01);
        push_byte(CH_LF);
        push_byte(CH_LF);
        push_byte(8'h71);
        push_byte(CH_QUOTE);
        push_byte(CH_COMMA);
        push_byte(CH_COMMA);
        push_eoi(8'hFF);
        // no records at all
        push_eoi(8'h55);
        // junk after a closing quote, ignored byte, then a zero byte ends
        push_byte(CH_QUOTE);
        push_byte(8'h7A);
        push_byte(CH_QUOTE);
        push_byte(8'h78);
        push_byte(8'h79);
        push_byte(CH_NUL);
        // lone cr after a closing quote
        push_byte(CH_QUOTE);
        push_byte(8'h71);
        push_byte(CH_QUOTE);
        push_byte(CH_CR);
        push_byte(8'h61);
        push_eoi(8'h00);
        // end inside quotes
        push_byte(CH_QUOTE);
        push_byte(8'h6F);
        push_eoi(8'h80);

        random_text(100);
        wait_drain();

        send_idle <= 45;
        recv_idle <= 38;
        write_cols(9'd3);
        random_text(100);
        wait_drain();

        send_idle <= 0;
        recv_idle <= 0;
        write_cols(9'd1);
        random_text(100);
        wait_drain();
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> csv_stream_parser_unit.f
+incdir+rtl
rtl/csvp_pkg.sv
rtl/csvp_core.sv
rtl/csvp_res_queue.sv
rtl/csv_stream_parser_unit.sv
rtl/csvp_checker.sv
dv/tb_csv_stream_parser_unit.sv
